[hdl/inl_pkg.sv]
// Shared constants and fixed-point helpers for the integer natural log unit.
package inl_pkg;

	localparam int INPUT_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int LOG_W           = 23;
	localparam int CONST_SCALE     = 32;
	localparam int HORNER_STEPS    = 4;

	// Magnitudes scaled by 2^32.
	localparam logic [63:0] K_LN2 = 64'd2977044472;
	localparam logic [63:0] K_C0  = 64'd7480947837;
	localparam logic [63:0] K_C1  = 64'd12077559706;
	localparam logic [63:0] K_C2  = 64'd6313416383;
	localparam logic [63:0] K_C3  = 64'd1920621543;
	localparam logic [63:0] K_C4  = 64'd242969955;

	// Round magnitude to nearest at frac fraction bits, then apply sign.
	function automatic logic signed [63:0] fix_const(logic [63:0] mag, logic neg, int frac);
		logic [63:0] r;
		r = (mag + (64'd1 << (CONST_SCALE - 1 - frac))) >> (CONST_SCALE - frac);
		return neg ? -$signed(r) : $signed(r);
	endfunction

	// Coefficient added after the k-th multiply (c3 first, c0 last).
	function automatic logic signed [63:0] horner_coef(int k, int frac);
		logic signed [63:0] c;
		case (k)
			0: c = fix_const(K_C3, 1'b0, frac);
			1: c = fix_const(K_C2, 1'b1, frac);
			2: c = fix_const(K_C1, 1'b0, frac);
			3: c = fix_const(K_C0, 1'b1, frac);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

[hdl/inl_front.sv]
// Front end: accepts requests, finds the top set bit and normalizes the mantissa.
module inl_front import inl_pkg::*; #(
	parameter int INPUT_WIDTH = INPUT_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int EW          = $clog2(INPUT_WIDTH),
	parameter int YW          = FRAC_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [INPUT_WIDTH-1:0] x_value,
	input  logic                   q_full,
	output logic                   push,
	output logic [YW-1:0]          push_y,
	output logic [EW-1:0]          push_e,
	output logic                   push_zero
);

	localparam int ZW = INPUT_WIDTH + FRAC_BITS;

	logic                   v_s1, v_s2;
	logic [INPUT_WIDTH-1:0] x_s1;
	logic [EW-1:0]          e_s1, e_s2;
	logic                   zero_s1, zero_s2;
	logic [YW-1:0]          y_s2;
	logic [EW-1:0]          msb;
	logic [EW-1:0]          sh;
	logic [ZW-1:0]          z;
	logic                   rdy_s1, rdy_s2;

	assign rdy_s2 = !v_s2 || !q_full;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign busy   = !rdy_s1;
	assign push   = v_s2 && !q_full;

	always_comb begin
		msb = '0;
		for (int i = 0; i < INPUT_WIDTH; i++) begin
			if (x_value[i]) msb = EW'(i);
		end
	end

	// Put the top set bit at the head of the word; truncation matches a right shift.
	assign sh = EW'(INPUT_WIDTH - 1) - e_s1;
	assign z  = {x_s1, {FRAC_BITS{1'b0}}} << sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= start;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			x_s1    <= x_value;
			e_s1    <= msb;
			zero_s1 <= ~|x_value;
		end
		if (rdy_s2) begin
			y_s2    <= z[ZW-1 -: YW];
			e_s2    <= e_s1;
			zero_s2 <= zero_s1;
		end
	end

	assign push_y    = y_s2;
	assign push_e    = e_s2;
	assign push_zero = zero_s2;

endmodule

[hdl/inl_queue.sv]
// Two-entry request queue between the front and back ends.
module inl_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output logic [DW-1:0] pop_data
);

	localparam int DEPTH = 2;

	logic [DW-1:0] mem_q [DEPTH];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          do_pop;

	assign full      = (cnt_q == 2'(DEPTH));
	assign pop_valid = (cnt_q != 2'd0);
	assign do_pop    = pop && pop_valid;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

[hdl/inl_horner_step.sv]
// One Horner step: multiply by the mantissa, truncate, add the next coefficient.
module inl_horner_step #(
	parameter int                    FRAC_BITS = 16,
	parameter int                    PW        = 20,
	parameter int                    YW        = 17,
	parameter logic signed [PW-1:0] COEF      = '0
) (
	input  logic                 clk,
	input  logic signed [PW-1:0] acc_in,
	input  logic [YW-1:0]        y_in,
	output logic signed [PW-1:0] acc_out,
	output logic [YW-1:0]        y_out
);

	localparam int MW = PW + YW + 1;

	logic signed [MW-1:0] prod_s1;
	logic [YW-1:0]        y_s1, y_s2;
	logic signed [PW-1:0] acc_s2;
	logic signed [MW-1:0] sum;

	assign sum = (prod_s1 >>> FRAC_BITS) + MW'(COEF);

	always_ff @(posedge clk) begin
		prod_s1 <= MW'(acc_in) * MW'($signed({1'b0, y_in}));
		y_s1    <= y_in;
		acc_s2  <= PW'(sum);
		y_s2    <= y_s1;
	end

	assign acc_out = acc_s2;
	assign y_out   = y_s2;

endmodule

[hdl/inl_back.sv]
// Back end: polynomial pipeline, exponent term and result register.
module inl_back import inl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int EW        = 5,
	parameter int YW        = FRAC_BITS + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [YW-1:0]           in_y,
	input  logic [EW-1:0]           in_e,
	input  logic                    in_zero,
	output logic                    done,
	output logic signed [LOG_W-1:0] log_value,
	output logic                    zero_input
);

	localparam int PW    = FRAC_BITS + 4;
	localparam int EL_W  = EW + FRAC_BITS + 1;
	localparam int DLY   = 2 * HORNER_STEPS;
	localparam int MX_W  = (PW > EL_W + 1) ? PW : EL_W + 1;
	localparam int SUM_W = ((MX_W > LOG_W) ? MX_W : LOG_W) + 1;
	localparam logic [FRAC_BITS:0] LN2_C = (FRAC_BITS + 1)'(fix_const(K_LN2, 1'b0, FRAC_BITS));
	localparam logic signed [PW-1:0] C4_C = PW'(fix_const(K_C4, 1'b1, FRAC_BITS));

	logic            v_s1;
	logic [YW-1:0]   y_s1;
	logic [EL_W-1:0] eln2_s1;
	logic            zero_s1;

	logic            v_dly_q    [DLY];
	logic            zero_dly_q [DLY];
	logic [EL_W-1:0] eln2_dly_q [DLY];

	logic signed [PW-1:0] acc_w [HORNER_STEPS+1];
	logic [YW-1:0]        y_w   [HORNER_STEPS+1];
	logic signed [SUM_W-1:0] sum;

	logic                    done_q, zero_q;
	logic signed [LOG_W-1:0] log_q;

	assign acc_w[0] = C4_C;
	assign y_w[0]   = y_s1;

	for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
		inl_horner_step #(
			.FRAC_BITS (FRAC_BITS),
			.PW        (PW),
			.YW        (YW),
			.COEF      (PW'(horner_coef(k, FRAC_BITS)))
		) u_step (
			.clk     (clk),
			.acc_in  (acc_w[k]),
			.y_in    (y_w[k]),
			.acc_out (acc_w[k+1]),
			.y_out   (y_w[k+1])
		);
	end

	assign sum = SUM_W'(acc_w[HORNER_STEPS]) + SUM_W'($signed({1'b0, eln2_dly_q[DLY-1]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < DLY; i++) v_dly_q[i] <= 1'b0;
		end else begin
			v_s1       <= in_valid;
			v_dly_q[0] <= v_s1;
			for (int i = 1; i < DLY; i++) v_dly_q[i] <= v_dly_q[i-1];
			done_q     <= v_dly_q[DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		y_s1          <= in_y;
		zero_s1       <= in_zero;
		eln2_s1       <= EL_W'(in_e) * EL_W'(LN2_C);
		zero_dly_q[0] <= zero_s1;
		eln2_dly_q[0] <= eln2_s1;
		for (int i = 1; i < DLY; i++) begin
			zero_dly_q[i] <= zero_dly_q[i-1];
			eln2_dly_q[i] <= eln2_dly_q[i-1];
		end
		zero_q <= zero_dly_q[DLY-1];
		log_q  <= zero_dly_q[DLY-1] ? '0 : sum[LOG_W-1:0];
	end

	assign done       = done_q;
	assign log_value  = log_q;
	assign zero_input = zero_q;

endmodule

[hdl/integer_natural_log_unit.sv]
// Top level of the integer natural log unit.
//
// Usage:
//   Request channel: drive x_value and raise start; the request is taken at
//   the rising edge where start is high and busy is low. One request may be
//   issued every cycle.
//   Result channel: done is high for one cycle with log_value (signed, 23 bits,
//   FRAC_BITS fraction bits) and zero_input. The receiver cannot stall; results
//   must be captured in the cycle done is high.
// Pipeline: between the accepting edge and done lie two front stages,
//   one queue slot, one back entry stage, a product and a sum register in each
//   of the four Horner steps, and one output register.
// Throughput: one result per cycle, set by the fully pipelined Horner
//   multipliers. The back end pops the queue whenever it holds an entry, so
//   busy stays low in normal operation.
// Reset: arst_n clears all valid flags and queue pointers; nothing is in flight
//   afterward and no result strobes until a new request arrives.
// A zero input returns zero_input = 1 and log_value = 0.
module integer_natural_log_unit import inl_pkg::*; #(
	parameter int INPUT_WIDTH = INPUT_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [INPUT_WIDTH-1:0]  x_value,
	output logic                    done,
	output logic signed [LOG_W-1:0] log_value,
	output logic                    zero_input
);

	localparam int EW = $clog2(INPUT_WIDTH);
	localparam int YW = FRAC_BITS + 1;
	localparam int QW = YW + EW + 1;

	logic          push, q_full, pop_valid;
	logic [YW-1:0] push_y, pop_y;
	logic [EW-1:0] push_e, pop_e;
	logic          push_zero, pop_zero;

	inl_front #(
		.INPUT_WIDTH (INPUT_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.EW          (EW),
		.YW          (YW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.x_value   (x_value),
		.q_full    (q_full),
		.push      (push),
		.push_y    (push_y),
		.push_e    (push_e),
		.push_zero (push_zero)
	);

	inl_queue #(
		.DW (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_y, push_e, push_zero}),
		.full      (q_full),
		.pop       (pop_valid),
		.pop_valid (pop_valid),
		.pop_data  ({pop_y, pop_e, pop_zero})
	);

	inl_back #(
		.FRAC_BITS (FRAC_BITS),
		.EW        (EW),
		.YW        (YW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pop_valid),
		.in_y       (pop_y),
		.in_e       (pop_e),
		.in_zero    (pop_zero),
		.done       (done),
		.log_value  (log_value),
		.zero_input (zero_input)
	);

endmodule

[dv/integer_natural_log_unit_tb.sv]
// Self-checking testbench for the integer natural log unit.
module integer_natural_log_unit_tb;
	import inl_pkg::*;

	localparam int INPUT_WIDTH  = INPUT_WIDTH_DEF;
	localparam int FRAC         = FRAC_BITS_DEF;
	localparam int LATENCY      = 12;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 333;
	localparam int NUM_PHASES   = 4;
	localparam int NUM_DIRECTED = 23;
	localparam int PHASE_IDLE [NUM_PHASES] = '{0, 58, 27, 0};

	typedef struct packed {
		logic signed [LOG_W-1:0] log_val;
		logic                    is_zero;
	} log_result_t;

	typedef struct packed {
		logic [INPUT_WIDTH-1:0]  x;
		logic                    given;
		logic signed [LOG_W-1:0] log_val;
		logic                    is_zero;
	} stim_row_t;

	// Only the zero input has its answer written in; the rest go through the predictor.
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{32'h0000_0000, 1'b1, 23'sd0, 1'b1},
		'{32'h0000_0001, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_0002, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_0003, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_0004, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_0005, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_0007, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_00FF, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_0100, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_FFFF, 1'b0, 23'sd0, 1'b0},
		'{32'h0001_0000, 1'b0, 23'sd0, 1'b0},
		'{32'h0001_0001, 1'b0, 23'sd0, 1'b0},
		'{32'h0001_FFFF, 1'b0, 23'sd0, 1'b0},
		'{32'h0002_0000, 1'b0, 23'sd0, 1'b0},
		'{32'h1234_5678, 1'b0, 23'sd0, 1'b0},
		'{32'h5555_5555, 1'b0, 23'sd0, 1'b0},
		'{32'hAAAA_AAAA, 1'b0, 23'sd0, 1'b0},
		'{32'h7FFF_FFFF, 1'b0, 23'sd0, 1'b0},
		'{32'h8000_0000, 1'b0, 23'sd0, 1'b0},
		'{32'h8000_0001, 1'b0, 23'sd0, 1'b0},
		'{32'hFFFF_FFFE, 1'b0, 23'sd0, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 23'sd0, 1'b0},
		'{32'h0000_0000, 1'b1, 23'sd0, 1'b1}
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [INPUT_WIDTH-1:0]  x_value;
	logic                    done;
	logic signed [LOG_W-1:0] log_value;
	logic                    zero_input;

	// Travels with each request so the monitor knows whether the answer is given.
	logic                    row_given;
	log_result_t             row_want;

	log_result_t             pending_logs [$];
	int                      error_count = 0;
	int                      quiet_cycles = 0;

	integer_natural_log_unit #(
		.INPUT_WIDTH(INPUT_WIDTH),
		.FRAC_BITS  (FRAC)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.x_value   (x_value),
		.done      (done),
		.log_value (log_value),
		.zero_input(zero_input)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Constant magnitude at 2^32 scale, rounded half away from zero to FRAC bits.
	function automatic longint round_coef(logic [63:0] mag);
		return longint'((mag + (64'd1 << (CONST_SCALE - 1 - FRAC))) >> (CONST_SCALE - FRAC));
	endfunction

	function automatic log_result_t predict_log(logic [INPUT_WIDTH-1:0] x);
		log_result_t      r;
		int               msb;
		longint           y;
		longint           p;
		logic signed [63:0] acc;
		r.is_zero = (x == '0);
		r.log_val = '0;
		if (x != '0) begin
			msb = 0;
			for (int i = 0; i < INPUT_WIDTH; i++)
				if (x[i])
					msb = i;
			// mantissa in [1,2) with FRAC fraction bits, low bits dropped
			y = longint'(x);
			if (msb >= FRAC)
				y = y >>> (msb - FRAC);
			else
				y = y << (FRAC - msb);
			p = -round_coef(K_C4);
			p = round_coef(K_C3) + ((p * y) >>> FRAC);
			p = -round_coef(K_C2) + ((p * y) >>> FRAC);
			p = round_coef(K_C1) + ((p * y) >>> FRAC);
			p = -round_coef(K_C0) + ((p * y) >>> FRAC);
			acc = p + longint'(msb) * round_coef(K_LN2);
			r.log_val = acc[LOG_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [INPUT_WIDTH-1:0] pick_operand();
		int unsigned k;
		logic [INPUT_WIDTH-1:0] v;
		k = $urandom_range(INPUT_WIDTH - 1, 0);
		case ($urandom_range(9, 0))
			0:       v = '0;
			1:       v = 32'd1 << k;
			2:       v = (32'd1 << k) - 32'd1;
			3:       v = (32'd1 << k) + 32'd1;
			4, 5, 6: v = $urandom;
			default: v = $urandom >> k;
		endcase
		return v;
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	task automatic send_request(input logic [INPUT_WIDTH-1:0] v, input logic given,
			input log_result_t want, input int idle_pct);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		x_value   <= v;
		row_given <= given;
		row_want  <= want;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_logs.size() != 0)
			@(posedge clk);
	endtask

	// Result checking and the watchdog.
	always @(posedge clk) begin
		log_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_logs.size() == 0) begin
					note_error($sformatf("unexpected result: log_value=%0d zero_input=%0b",
						log_value, zero_input));
				end else begin
					want = pending_logs.pop_front();
					if (log_value !== want.log_val)
						note_error($sformatf("log_value mismatch: expected %0d, got %0d",
							want.log_val, log_value));
					if (zero_input !== want.is_zero)
						note_error($sformatf("zero_input mismatch: expected %0b, got %0b",
							want.is_zero, zero_input));
				end
			end
			if (start && !busy)
				pending_logs.push_back(row_given ? row_want : predict_log(x_value));
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		x_value   <= '0;
		row_given <= 1'b0;
		row_want  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_request(DIRECTED[i].x, DIRECTED[i].given,
				'{DIRECTED[i].log_val, DIRECTED[i].is_zero}, 0);
		drain_results();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int n = 0; n < PHASE_ITEMS; n++)
				// every third stretch of 40 requests runs back to back
				send_request(pick_operand(), 1'b0, '0,
					((n / 40) % 3 == 2) ? 0 : PHASE_IDLE[ph]);
			// hold off until the pipeline is empty
			drain_results();
		end

		repeat (2 * LATENCY) @(posedge clk);
		if (pending_logs.size() != 0)
			note_error($sformatf("%0d results never arrived", pending_logs.size()));
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
